### design/x86alu_pkg.sv
// Shared types and constants for the x86 integer ALU with status flags.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package x86alu_pkg;

    localparam int DATA_W          = 64;
    localparam int IDX_W           = 6;
    localparam int EW_W            = 7;
    localparam int FLAG_W          = 6;
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int BYTES_PER_WORD  = DATA_W / 8;

    // modulo-by-constant support for the bit index when MAX_WIDTH is not a power of two
    localparam int MOD_PROD_W = 14;
    localparam int MOD_SUM_W  = 17;
    localparam int MOD_Q_W    = 15;
    localparam int RECIP_W    = 21;
    localparam int MOD_SHIFT  = 23;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // flag bit positions
    localparam int FL_CF = 0;
    localparam int FL_PF = 1;
    localparam int FL_AF = 2;
    localparam int FL_ZF = 3;
    localparam int FL_SF = 4;
    localparam int FL_OF = 5;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_ADC  = 4'd1,
        CMD_SUB  = 4'd2,
        CMD_SBB  = 4'd3,
        CMD_CMP  = 4'd4,
        CMD_AND  = 4'd5,
        CMD_OR   = 4'd6,
        CMD_XOR  = 4'd7,
        CMD_ADCX = 4'd8,
        CMD_BT   = 4'd9,
        CMD_BTC  = 4'd10,
        CMD_BTR  = 4'd11,
        CMD_BTS  = 4'd12,
        CMD_CMOV = 4'd13
    } cmd_t;

    typedef struct packed {
        logic [3:0]        command;
        logic [1:0]        width_sel;
        logic [1:0]        source_width_sel;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [3:0]        condition;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_back;
        logic [FLAG_W-1:0] flags_out;
    } out_item_t;

    // decoded operation handed from the front end to the execute stage
    typedef struct packed {
        logic [3:0]        cmd;
        logic [IDX_W-1:0]  top;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [IDX_W-1:0]  bit_idx;
        logic [3:0]        cond;
    } exec_t;

    // operand width in bits for a width code, limited to maxw
    function automatic logic [EW_W-1:0] eff_width(logic [1:0] sel, logic [EW_W-1:0] maxw);
        logic [EW_W-1:0] w;
        w = EW_W'(8) << sel;
        if (w > maxw)
            w = maxw;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] width_mask(logic [EW_W-1:0] w);
        logic [DATA_W-1:0] m;
        for (int i = 0; i < DATA_W; i++)
            m[i] = (EW_W'(i) < w);
        return m;
    endfunction

endpackage

`default_nettype wire

### design/x86alu_front.sv
// Front end: accepts request beats, decodes widths, sign-extends the source
// and reduces the bit-test index. Two register stages. Uses x86alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86alu_front
    import x86alu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire in_item_t req,
    output logic          q_valid,
    input  wire logic     q_ready,
    output exec_t         q_data
);

    localparam logic [EW_W-1:0]      MAXW    = EW_W'(MAX_WIDTH);
    localparam bit                   IS_POW2 = ((MAX_WIDTH & (MAX_WIDTH - 1)) == 0);
    localparam logic [RECIP_W-1:0]   RECIP   =
        RECIP_W'(((1 << MOD_SHIFT) + MAX_WIDTH - 1) / MAX_WIDTH);
    localparam logic [MOD_SUM_W-1:0] MODULUS = MOD_SUM_W'(MAX_WIDTH);

    typedef struct packed {
        exec_t                ent;
        logic                 use_mod;
        logic [MOD_SUM_W-1:0] msum;
    } s1_t;

    typedef struct packed {
        exec_t                ent;
        logic                 use_mod;
        logic [MOD_SUM_W-1:0] msum;
        logic [MOD_Q_W-1:0]   quot;
    } s2_t;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s1_free, s2_free;

    logic [EW_W-1:0]      w_val, sw_val, sw2;
    logic [DATA_W-1:0]    mask_w, mask_sw, mask_sw2;
    logic [DATA_W-1:0]    braw;
    logic                 sgn;
    logic [IDX_W-1:0]     top;
    logic [MOD_SUM_W-1:0] msum;
    logic [MOD_PROD_W-1:0] bprod [BYTES_PER_WORD];

    logic [MOD_Q_W+MOD_SHIFT-1:0] qprod;
    logic [MOD_SUM_W-1:0]         rem;

    assign s2_free   = !s2_valid_reg || q_ready;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign req_ready = s1_free;
    assign q_valid   = s2_valid_reg;

    // decode and sign extension
    always_comb
    begin
        w_val    = eff_width(req.width_sel, MAXW);
        sw_val   = eff_width(req.source_width_sel, MAXW);
        sw2      = (sw_val > w_val) ? w_val : sw_val;
        mask_w   = width_mask(w_val);
        mask_sw  = width_mask(sw_val);
        mask_sw2 = width_mask(sw2);
        braw     = req.operand_b & mask_sw;
        sgn      = braw[IDX_W'(sw2 - EW_W'(1))];
        top      = IDX_W'(w_val - EW_W'(1));

        s1_next.ent.cmd     = req.command;
        s1_next.ent.top     = top;
        s1_next.ent.mask    = mask_w;
        s1_next.ent.a       = req.operand_a & mask_w;
        s1_next.ent.b       = ((braw & mask_sw2) | (sgn ? ~mask_sw2 : '0)) & mask_w;
        s1_next.ent.bit_idx = braw[IDX_W-1:0] & top;
        s1_next.ent.cond    = req.condition;
        s1_next.use_mod     = (w_val == MAXW) && !IS_POW2;
        s1_next.msum        = msum;
    end

    // braw mod MAX_WIDTH: fold each byte with its weight 256^k mod MAX_WIDTH
    for (genvar k = 0; k < BYTES_PER_WORD; k++)
    begin : g_res
        localparam longint unsigned BYTE_WT = 64'd1 << (8 * k);
        localparam logic [IDX_W-1:0] RES = IDX_W'(BYTE_WT % MAX_WIDTH);
        assign bprod[k] = MOD_PROD_W'(braw[8*k +: 8]) * MOD_PROD_W'(RES);
    end

    always_comb
    begin
        msum = '0;
        for (int k = 0; k < BYTES_PER_WORD; k++)
            msum = msum + MOD_SUM_W'(bprod[k]);
    end

    // stage 2: quotient by reciprocal multiply (exact for sums below 2^17)
    always_comb
    begin
        qprod           = (MOD_Q_W+MOD_SHIFT)'(s1_reg.msum) * (MOD_Q_W+MOD_SHIFT)'(RECIP);
        s2_next.ent     = s1_reg.ent;
        s2_next.use_mod = s1_reg.use_mod;
        s2_next.msum    = s1_reg.msum;
        s2_next.quot    = qprod[MOD_SHIFT +: MOD_Q_W];
    end

    always_comb
    begin
        rem    = s2_reg.msum - MOD_SUM_W'(MOD_SUM_W'(s2_reg.quot) * MODULUS);
        q_data = s2_reg.ent;
        if (s2_reg.use_mod)
            q_data.bit_idx = rem[IDX_W-1:0];
    end

    always_comb
    begin
        s1_valid_next = s1_free ? req_valid : s1_valid_reg;
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && req_valid)
            s1_reg <= s1_next;
        if (s2_free && s1_valid_reg)
            s2_reg <= s2_next;
    end

endmodule

`default_nettype wire

### design/x86alu_queue.sv
// Two-entry queue of decoded operations between front end and execute stage.
// Uses exec_t and queue constants from x86alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86alu_queue
    import x86alu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  enq_valid,
    output logic       enq_ready,
    input  wire exec_t enq_data,
    output logic       deq_valid,
    input  wire logic  deq_ready,
    output exec_t      deq_data
);

    exec_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign enq_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_data  = entries_reg[rd_ptr_reg];
    assign push      = enq_valid && enq_ready;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= enq_data;
    end

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push != pop |=> count_reg == ($past(count_reg) + ($past(push) ? 2'd1 : 2'd3)))
        else $error("queue count does not follow push/pop");

    a_no_deq_after_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push && count_reg == QCNT_W'(1) |=> !deq_valid)
        else $error("queue shows data after last entry popped");

endmodule

`default_nettype wire

### design/x86alu_back.sv
// Execute stage: arithmetic, logic, bit test and cmov on a decoded operation,
// holds the status flags and the response register. Uses x86alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86alu_back
    import x86alu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  ex_valid,
    output logic       ex_ready,
    input  wire exec_t ex,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output out_item_t  rsp
);

    typedef enum logic [2:0] {
        CG_O  = 3'd0,
        CG_B  = 3'd1,
        CG_E  = 3'd2,
        CG_BE = 3'd3,
        CG_S  = 3'd4,
        CG_P  = 3'd5,
        CG_L  = 3'd6,
        CG_LE = 3'd7
    } cond_grp_t;

    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              take;

    logic [DATA_W-1:0] r, sum, dif, bitmask;
    logic              cin, cy;

    function automatic logic [FLAG_W-1:0] res_flags(logic [DATA_W-1:0] v, logic [IDX_W-1:0] t);
        logic [FLAG_W-1:0] f;
        f        = '0;
        f[FL_PF] = ~^v[7:0];
        f[FL_ZF] = (v == '0);
        f[FL_SF] = v[t];
        return f;
    endfunction

    function automatic logic cond_holds(logic [3:0] c, logic [FLAG_W-1:0] f);
        logic t;
        unique case (cond_grp_t'(c[3:1]))
            CG_O:  t = f[FL_OF];
            CG_B:  t = f[FL_CF];
            CG_E:  t = f[FL_ZF];
            CG_BE: t = f[FL_CF] | f[FL_ZF];
            CG_S:  t = f[FL_SF];
            CG_P:  t = f[FL_PF];
            CG_L:  t = f[FL_SF] ^ f[FL_OF];
            CG_LE: t = f[FL_ZF] | (f[FL_SF] ^ f[FL_OF]);
        endcase
        return c[0] ? !t : t;
    endfunction

    assign ex_ready  = !out_valid_reg || rsp_ready;
    assign take      = ex_valid && ex_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        cin        = flags_reg[FL_CF];
        flags_next = flags_reg;
        r          = ex.a;
        out_next.write_back = 1'b0;

        sum     = (ex.a + ex.b + DATA_W'((ex.cmd == CMD_ADD) ? 1'b0 : cin)) & ex.mask;
        dif     = (ex.a - ex.b - DATA_W'((ex.cmd == CMD_SBB) ? cin : 1'b0)) & ex.mask;
        bitmask = DATA_W'(1) << ex.bit_idx;
        cy      = 1'b0;

        unique case (ex.cmd) inside
            CMD_ADD, CMD_ADC, CMD_ADCX:
            begin
                r  = sum;
                cy = 1'(((ex.a & ex.b) | ((ex.a | ex.b) & ~sum)) >> ex.top);
                if (ex.cmd == CMD_ADCX)
                    flags_next[FL_CF] = cy;
                else
                begin
                    flags_next        = res_flags(sum, ex.top);
                    flags_next[FL_CF] = cy;
                    flags_next[FL_OF] = 1'(((ex.a ^ sum) & (ex.b ^ sum)) >> ex.top);
                    flags_next[FL_AF] = ex.a[4] ^ ex.b[4] ^ sum[4];
                end
                out_next.write_back = 1'b1;
            end
            CMD_SUB, CMD_SBB, CMD_CMP:
            begin
                flags_next        = res_flags(dif, ex.top);
                flags_next[FL_CF] = 1'(((~ex.a & ex.b) | ((~ex.a | ex.b) & dif)) >> ex.top);
                flags_next[FL_OF] = 1'(((ex.a ^ ex.b) & (ex.a ^ dif)) >> ex.top);
                flags_next[FL_AF] = ex.a[4] ^ ex.b[4] ^ dif[4];
                if (ex.cmd != CMD_CMP)
                begin
                    r = dif;
                    out_next.write_back = 1'b1;
                end
            end
            CMD_AND, CMD_OR, CMD_XOR:
            begin
                if (ex.cmd == CMD_AND)
                    r = ex.a & ex.b;
                else if (ex.cmd == CMD_OR)
                    r = ex.a | ex.b;
                else
                    r = ex.a ^ ex.b;
                flags_next = res_flags(r, ex.top);
                out_next.write_back = 1'b1;
            end
            CMD_BT, CMD_BTC, CMD_BTR, CMD_BTS:
            begin
                flags_next[FL_CF] = ex.a[ex.bit_idx];
                if (ex.cmd == CMD_BTC)
                    r = ex.a ^ bitmask;
                else if (ex.cmd == CMD_BTR)
                    r = ex.a & ~bitmask;
                else if (ex.cmd == CMD_BTS)
                    r = ex.a | bitmask;
                out_next.write_back = (ex.cmd != CMD_BT);
            end
            CMD_CMOV:
            begin
                r = cond_holds(ex.cond, flags_reg) ? ex.b : ex.a;
                out_next.write_back = 1'b1;
            end
            default:
            begin
                // unused codes: no operation
                r = ex.a;
            end
        endcase

        out_next.result    = r & ex.mask;
        out_next.flags_out = flags_next;
        out_valid_next     = take ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg && (out_reg.flags_out == flags_reg))
        else $error("reported flags differ from held flags");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(flags_reg))
        else $error("flags changed without an operation");

    a_result_width: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (out_reg.result & ~$past(ex.mask)) == '0)
        else $error("result has bits above operand width");

    a_no_wb_compare: assert property (@(posedge clk) disable iff (!rst_n)
        take && (ex.cmd == CMD_CMP || ex.cmd == CMD_BT) |=> !out_reg.write_back)
        else $error("compare or bit test marked for write-back");

endmodule

`default_nettype wire

### design/x86_integer_alu_with_flags.sv
// x86 integer ALU with status flags: top level joining front end, queue and
// execute stage. Uses x86alu_pkg, x86alu_front, x86alu_queue, x86alu_back.
`timescale 1ns / 1ps
`default_nettype none

// Executes one x86 integer operation (add, adc, sub, sbb, cmp, and, or, xor,
// adcx, bt, btc, btr, bts, cmov) at 8/16/32/64-bit width and keeps CF, PF, AF,
// ZF, SF and OF between operations (all clear after reset). One request beat
// is taken every clock while req_ready is high; an accepted request loads the
// first front-end stage, then passes through the second stage and the
// two-entry queue into the response register. The flags loop is closed inside
// the execute stage, so dependent operations issue back to back. Backpressure
// on the response side fills the queue and then the front stages before
// req_ready drops.
module x86_integer_alu_with_flags
    import x86alu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire in_item_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output out_item_t     rsp
);

    logic  fq_valid, fq_ready;
    exec_t fq_data;
    logic  qb_valid, qb_ready;
    exec_t qb_data;

    x86alu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    x86alu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (fq_valid),
        .enq_ready (fq_ready),
        .enq_data  (fq_data),
        .deq_valid (qb_valid),
        .deq_ready (qb_ready),
        .deq_data  (qb_data)
    );

    x86alu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ex_valid  (qb_valid),
        .ex_ready  (qb_ready),
        .ex        (qb_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
